FILE: hw/rtl/swmm_pkg.sv
`default_nettype none

package swmm_pkg;

    localparam int SAMPLE_W            = 32;
    localparam int CFG_W               = 7;
    localparam int WINDOW_LENGTH_RESET = 5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       series_start;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] window_max;
        logic signed [SAMPLE_W-1:0] window_min;
        logic                       window_full;
    } out_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] hi;
        logic signed [SAMPLE_W-1:0] lo;
    } minmax_t;

endpackage

`default_nettype wire

FILE: hw/rtl/swmm_cell.sv
`default_nettype none

module swmm_cell
    import swmm_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       advance,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire minmax_t                    nbr,
    output minmax_t                         held
);

    minmax_t held_reg;
    minmax_t held_next;

    always_comb begin
        held_next.hi = ($signed(nbr.hi) > sample) ? nbr.hi : sample;
        held_next.lo = ($signed(nbr.lo) < sample) ? nbr.lo : sample;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            held_reg <= held_next;
        end
    end

    assign held = held_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sliding_window_min_max.sv
// Sliding-window maximum and minimum over a stream of signed 32-bit samples.
// The window covers the last window_length samples of the current series,
// the new one included, and window_length above WINDOW_MAX counts as
// WINDOW_MAX. Samples that have left a shorter window stay out when
// window_length grows, so the window then widens by one sample per transfer
// until it reaches the new length. A row of WINDOW_MAX-1 cells holds, in
// cell k, the maximum and minimum of the k+1 samples before the newest; each
// transfer shifts the row by one, every cell comparing the new sample with
// its neighbour's value. One sample is taken every cycle while the result
// side keeps up; its result sits in the output register from the next cycle
// on. Results stay 0 with window_full low until window_length samples of the
// series have been seen, and always when window_length is 0. series_start
// opens a new series with its own sample. A window_length write takes effect
// for the next sample.

`default_nettype none

module sliding_window_min_max
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_t              s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_t                  m_data
);

    localparam int NCELL = (WINDOW_MAX > 1) ? WINDOW_MAX - 1 : 1;
    localparam int LW    = $clog2(WINDOW_MAX + 1);
    localparam int IW    = (NCELL > 1) ? $clog2(NCELL) : 1;

    logic [CFG_W-1:0] window_length_reg;
    logic [LW-1:0]    seen_reg;
    logic [LW-1:0]    seen_next;
    logic [LW-1:0]    span_reg;
    logic [LW-1:0]    span_next;
    logic             m_valid_reg;
    out_t             m_data_reg;
    out_t             m_data_next;

    logic                       accept;
    logic [LW-1:0]              len_eff;
    logic [IW-1:0]              sel_idx;
    logic                       full;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] win_hi;
    logic signed [SAMPLE_W-1:0] win_lo;
    minmax_t                    sel;
    minmax_t                    held [NCELL];
    minmax_t                    nbr  [NCELL];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign x       = s_data.sample;

    always_comb begin
        if (int'(window_length_reg) > WINDOW_MAX) begin
            len_eff = LW'(WINDOW_MAX);
        end else begin
            len_eff = LW'(window_length_reg);
        end
    end

    genvar k;
    generate
        for (k = 0; k < NCELL; k++) begin : g_cell
            if (k == 0) begin : g_head
                assign nbr[k] = '{hi: x, lo: x};
            end else begin : g_body
                assign nbr[k] = held[k-1];
            end
            swmm_cell u_cell (
                .aclk    (aclk),
                .advance (accept),
                .sample  (x),
                .nbr     (nbr[k]),
                .held    (held[k])
            );
        end
    endgenerate

    // widen by one sample per transfer, never beyond the current length
    always_comb begin
        if (s_data.series_start) begin
            span_next = (len_eff != '0) ? LW'(1) : '0;
        end else if (span_reg < len_eff) begin
            span_next = span_reg + LW'(1);
        end else begin
            span_next = len_eff;
        end
    end

    assign sel_idx = IW'(span_next - LW'(2));

    always_comb begin
        sel = held[0];
        for (int i = 0; i < NCELL; i++) begin
            if (IW'(i) == sel_idx) begin
                sel = held[i];
            end
        end
    end

    always_comb begin
        if ((span_next == '0) || (span_next == LW'(1))) begin
            win_hi = x;
            win_lo = x;
        end else begin
            win_hi = ($signed(sel.hi) > x) ? sel.hi : x;
            win_lo = ($signed(sel.lo) < x) ? sel.lo : x;
        end
    end

    always_comb begin
        if (s_data.series_start) begin
            seen_next = LW'(1);
        end else if (seen_reg < LW'(WINDOW_MAX)) begin
            seen_next = seen_reg + LW'(1);
        end else begin
            seen_next = seen_reg;
        end
        full = (len_eff != '0) && (seen_next >= len_eff);
        if (full) begin
            m_data_next = '{window_max: win_hi, window_min: win_lo, window_full: 1'b1};
        end else begin
            m_data_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= CFG_W'(WINDOW_LENGTH_RESET);
            seen_reg          <= '0;
            span_reg          <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                window_length_reg <= cfg_wdata;
            end
            if (accept) begin
                seen_reg    <= seen_next;
                span_reg    <= span_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until its transfer
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/swmm_checker.sv
`default_nettype none

module swmm_checker
    import swmm_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted sample gave no result");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    a_not_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.window_full) |->
            (m_data.window_max == '0 && m_data.window_min == '0))
        else $error("partial window result not zero");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.window_full) |->
            ($signed(m_data.window_max) >= $signed(m_data.window_min)))
        else $error("window maximum below minimum");

endmodule

bind sliding_window_min_max swmm_checker u_swmm_checker (.*);

`default_nettype wire
